// ===== hdl/psq_pkg.sv =====
// Shared constants, codes and types of the pending signal queue.
package psq_pkg;

    // Queue size and field widths.
    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 16;
    localparam int SIG_W          = 4;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int LEN_W          = 5;
    localparam int ADDR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W        = THREAD_ID_BITS + SIG_W;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_APPEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BY_THREAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BY_SIGNAL = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/psq_in_if.sv =====
// Request channel: valid/ready handshake with the request fields.
interface psq_in_if;
    logic                                valid;
    logic                                ready;
    logic [psq_pkg::MODE_W-1:0]          mode;
    logic [psq_pkg::THREAD_ID_BITS-1:0]  thread_id;
    logic [psq_pkg::SIG_W-1:0]           signal_num;

    modport source (output valid, output mode, output thread_id, output signal_num,
                    input ready);
    modport sink   (input valid, input mode, input thread_id, input signal_num,
                    output ready);
endinterface

// ===== hdl/psq_out_if.sv =====
// Result channel: valid/ready handshake with the result fields.
interface psq_out_if;
    logic                                valid;
    logic                                ready;
    logic [psq_pkg::STATUS_W-1:0]        status;
    logic [psq_pkg::THREAD_ID_BITS-1:0]  out_thread_id;
    logic [psq_pkg::SIG_W-1:0]           out_signal_num;
    logic [psq_pkg::LEN_W-1:0]           length;

    modport source (output valid, output status, output out_thread_id,
                    output out_signal_num, output length, input ready);
    modport sink   (input valid, input status, input out_thread_id,
                    input out_signal_num, input length, output ready);
endinterface

// ===== hdl/pending_signal_queue_keyed_remove.sv =====
// Top level of the pending signal queue with keyed removal.
//
// Requests arrive on in_ch (mode, thread_id, signal_num) and each gives one
// result on out_ch (status, out_thread_id, out_signal_num, length). A transfer
// happens on a clock edge where valid and ready are both high.
// The block works on one request at a time; in_ch.ready is high only while idle.
// Records sit in a RAM of QUEUE_DEPTH entries, oldest first. Removals scan the
// RAM one entry per cycle through a single compare unit, then close the gap one
// record per cycle with a read-ahead/write-back pair on the RAM ports.
// An append, or any request on an empty queue, goes from capture straight to
// the result. A pop or keyed removal first scans the records, oldest first,
// and when one matches closes the gap before the result is loaded. A new
// request is taken the cycle after the result is loaded into the output
// register.
// If the receiver stalls, the result waits in the output register; the next
// request is still accepted and runs until it needs that register.
// Reset empties the queue at once; no clearing pass is needed.
module pending_signal_queue_keyed_remove (
    input logic       clk,
    input logic       rst_n,
    psq_in_if.sink    in_ch,
    psq_out_if.source out_ch
);

    logic                               hit;
    logic [psq_pkg::MODE_W-1:0]         mode;
    logic [psq_pkg::THREAD_ID_BITS-1:0] key_thread;
    logic [psq_pkg::SIG_W-1:0]          key_signal;
    logic                               ram_we;
    logic [psq_pkg::ADDR_W-1:0]         ram_waddr;
    logic [psq_pkg::ENTRY_W-1:0]        ram_wdata;
    logic [psq_pkg::ADDR_W-1:0]         ram_raddr;
    logic [psq_pkg::ENTRY_W-1:0]        ram_rdata;

    // Record store.
    psq_ram #(
        .WIDTH (psq_pkg::ENTRY_W),
        .DEPTH (psq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Match unit shared by every scan step.
    psq_cmp u_cmp (
        .mode       (mode),
        .key_thread (key_thread),
        .key_signal (key_signal),
        .entry      (ram_rdata),
        .hit        (hit)
    );

    // Sequencer and result register.
    psq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .hit        (hit),
        .mode       (mode),
        .key_thread (key_thread),
        .key_signal (key_signal),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule

// ===== hdl/psq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/psq_cmp.sv =====
// Shared match unit: decides whether the record read from the queue is the one to remove.
module psq_cmp (
    input  logic [psq_pkg::MODE_W-1:0]         mode,
    input  logic [psq_pkg::THREAD_ID_BITS-1:0] key_thread,
    input  logic [psq_pkg::SIG_W-1:0]          key_signal,
    input  logic [psq_pkg::ENTRY_W-1:0]        entry,
    output logic                               hit
);

    logic [psq_pkg::THREAD_ID_BITS-1:0] entry_thread;
    logic [psq_pkg::SIG_W-1:0]          entry_signal;

    assign entry_thread = entry[psq_pkg::ENTRY_W-1:psq_pkg::SIG_W];
    assign entry_signal = entry[psq_pkg::SIG_W-1:0];

    // A pop takes the oldest record; keyed removals compare one field.
    always_comb
    begin
        case (mode)
            psq_pkg::MODE_POP:       hit = 1'b1;
            psq_pkg::MODE_BY_THREAD: hit = (entry_thread == key_thread);
            psq_pkg::MODE_BY_SIGNAL: hit = (entry_signal == key_signal);
            default:                 hit = 1'b0;
        endcase
    end

endmodule

// ===== hdl/psq_seq.sv =====
// Sequencer: request capture, scan and close-up over the record RAM, result register.
module psq_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    psq_in_if.sink                             in_ch,
    psq_out_if.source                          out_ch,
    input  logic                               hit,
    output logic [psq_pkg::MODE_W-1:0]         mode,
    output logic [psq_pkg::THREAD_ID_BITS-1:0] key_thread,
    output logic [psq_pkg::SIG_W-1:0]          key_signal,
    output logic                               ram_we,
    output logic [psq_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [psq_pkg::ENTRY_W-1:0]        ram_wdata,
    output logic [psq_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [psq_pkg::ENTRY_W-1:0]        ram_rdata
);

    psq_pkg::state_t state_reg, state_next;

    logic [psq_pkg::MODE_W-1:0]         mode_reg, mode_next;
    logic [psq_pkg::THREAD_ID_BITS-1:0] key_tid_reg, key_tid_next;
    logic [psq_pkg::SIG_W-1:0]          key_sig_reg, key_sig_next;
    logic [psq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [psq_pkg::ADDR_W-1:0]         ptr_reg, ptr_next;
    logic [psq_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [psq_pkg::THREAD_ID_BITS-1:0] res_tid_reg, res_tid_next;
    logic [psq_pkg::SIG_W-1:0]          res_sig_reg, res_sig_next;
    logic                               out_valid_reg, out_valid_next;
    logic [psq_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [psq_pkg::THREAD_ID_BITS-1:0] out_tid_reg, out_tid_next;
    logic [psq_pkg::SIG_W-1:0]          out_sig_reg, out_sig_next;
    logic [psq_pkg::LEN_W-1:0]          out_len_reg, out_len_next;

    logic                               in_xfer;
    logic                               out_free;
    logic [psq_pkg::CNT_W-1:0]          ptr_inc;
    logic [psq_pkg::CNT_W-1:0]          ptr_inc2;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign ptr_inc  = psq_pkg::CNT_W'(ptr_reg) + psq_pkg::CNT_W'(1);
    assign ptr_inc2 = psq_pkg::CNT_W'(ptr_reg) + psq_pkg::CNT_W'(2);

    // Handshake and compare-unit drive.
    assign in_ch.ready           = (state_reg == psq_pkg::ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.out_thread_id  = out_tid_reg;
    assign out_ch.out_signal_num = out_sig_reg;
    assign out_ch.length         = out_len_reg;
    assign mode                  = mode_reg;
    assign key_thread            = key_tid_reg;
    assign key_signal            = key_sig_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = psq_pkg::ST_START;
                end
            end
            psq_pkg::ST_START:
            begin
                if (mode_reg == psq_pkg::MODE_APPEND || count_reg == '0)
                begin
                    state_next = psq_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = psq_pkg::ST_SCAN;
                end
            end
            psq_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = psq_pkg::ST_SHIFT;
                end
                else if (ptr_inc == count_reg)
                begin
                    state_next = psq_pkg::ST_FINISH;
                end
            end
            psq_pkg::ST_SHIFT:
            begin
                if (ptr_inc >= count_reg)
                begin
                    state_next = psq_pkg::ST_FINISH;
                end
            end
            psq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = psq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result register.
    always_comb
    begin
        mode_next       = mode_reg;
        key_tid_next    = key_tid_reg;
        key_sig_next    = key_sig_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_tid_next    = res_tid_reg;
        res_sig_next    = res_sig_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_tid_next    = out_tid_reg;
        out_sig_next    = out_sig_reg;
        out_len_next    = out_len_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = ptr_reg;
        case (state_reg)
            psq_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next       = in_ch.mode;
                    key_tid_next    = in_ch.thread_id;
                    key_sig_next    = in_ch.signal_num;
                    res_status_next = psq_pkg::STATUS_NONE;
                    res_tid_next    = '0;
                    res_sig_next    = '0;
                    ptr_next        = '0;
                end
            end
            psq_pkg::ST_START:
            begin
                // The oldest record is fetched so the scan can start next cycle.
                ram_raddr = '0;
                if (mode_reg == psq_pkg::MODE_APPEND)
                begin
                    if (count_reg == psq_pkg::CNT_W'(psq_pkg::QUEUE_DEPTH))
                    begin
                        res_status_next = psq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = psq_pkg::ADDR_W'(count_reg);
                        ram_wdata       = {key_tid_reg, key_sig_reg};
                        count_next      = count_reg + psq_pkg::CNT_W'(1);
                        res_status_next = psq_pkg::STATUS_DONE;
                    end
                end
            end
            psq_pkg::ST_SCAN:
            begin
                // The read data holds the record at ptr; the one behind it is fetched.
                ram_raddr = psq_pkg::ADDR_W'(ptr_inc);
                if (hit)
                begin
                    res_status_next = psq_pkg::STATUS_DONE;
                    res_tid_next    = ram_rdata[psq_pkg::ENTRY_W-1:psq_pkg::SIG_W];
                    res_sig_next    = ram_rdata[psq_pkg::SIG_W-1:0];
                end
                else if (ptr_inc != count_reg)
                begin
                    ptr_next = psq_pkg::ADDR_W'(ptr_inc);
                end
            end
            psq_pkg::ST_SHIFT:
            begin
                // Move the record behind ptr up one place, one record per cycle.
                ram_raddr = psq_pkg::ADDR_W'(ptr_inc2);
                if (ptr_inc < count_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = ram_rdata;
                    ptr_next  = psq_pkg::ADDR_W'(ptr_inc);
                end
                else
                begin
                    count_next = count_reg - psq_pkg::CNT_W'(1);
                end
            end
            psq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tid_next    = res_tid_reg;
                    out_sig_next    = res_sig_reg;
                    out_len_next    = psq_pkg::LEN_W'(count_reg);
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_tid_reg    <= key_tid_next;
        key_sig_reg    <= key_sig_next;
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_tid_reg    <= res_tid_next;
        res_sig_reg    <= res_sig_next;
        out_status_reg <= out_status_next;
        out_tid_reg    <= out_tid_next;
        out_sig_reg    <= out_sig_next;
        out_len_reg    <= out_len_next;
    end

endmodule

// ===== hdl/psq_chk.sv =====
// Port-level checks on the result channel of the queue, bound to the top level.
module psq_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [psq_pkg::STATUS_W-1:0]       status,
    input logic [psq_pkg::THREAD_ID_BITS-1:0] out_thread_id,
    input logic [psq_pkg::SIG_W-1:0]          out_signal_num,
    input logic [psq_pkg::LEN_W-1:0]          length
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // The reported count never exceeds the queue size.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length <= psq_pkg::LEN_W'(psq_pkg::QUEUE_DEPTH))
        else $error("length beyond queue size");

    // A rejected append only happens on a full queue.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == psq_pkg::STATUS_FULL
            |-> length == psq_pkg::LEN_W'(psq_pkg::QUEUE_DEPTH))
        else $error("full status with room left");

    // Failed and rejected requests return an empty record.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == psq_pkg::STATUS_NONE || status == psq_pkg::STATUS_FULL)
            |-> out_thread_id == '0 && out_signal_num == '0)
        else $error("record fields set without a removal");

    // Only the three defined status codes ever appear on a valid result.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == psq_pkg::STATUS_DONE || status == psq_pkg::STATUS_NONE
            || status == psq_pkg::STATUS_FULL)
        else $error("undefined status code");

endmodule

bind pending_signal_queue_keyed_remove psq_chk u_psq_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .out_thread_id  (out_ch.out_thread_id),
    .out_signal_num (out_ch.out_signal_num),
    .length         (out_ch.length)
);
